// File: sv/tls_pkg.sv
// shared types and constants of the tunnel link supervisor
package tls_pkg;

	typedef enum logic [2:0] {
		PH_DISABLED   = 3'd0,
		PH_WAITING    = 3'd1,
		PH_CONNECTING = 3'd2,
		PH_BACKOFF    = 3'd3,
		PH_CONNECTED  = 3'd4
	} phase_t;

	// configuration register indexes
	localparam logic [2:0] REG_ALT_MODE         = 3'd0;
	localparam logic [2:0] REG_HANDSHAKE_BUDGET = 3'd1;
	localparam logic [2:0] REG_ALT_BUDGET       = 3'd2;
	localparam logic [2:0] REG_SILENCE_LIMIT    = 3'd3;
	localparam logic [2:0] REG_BACKOFF_FLOOR    = 3'd4;
	localparam logic [2:0] REG_BACKOFF_CAP      = 3'd5;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// reset values
	localparam logic [7:0] RST_HANDSHAKE_BUDGET = 8'd20;
	localparam logic [7:0] RST_ALT_BUDGET       = 8'd90;
	localparam logic [7:0] RST_SILENCE_LIMIT    = 8'd30;
	localparam logic [7:0] RST_BACKOFF_FLOOR    = 8'd5;
	localparam logic [7:0] RST_BACKOFF_CAP      = 8'd60;
	localparam logic [7:0] RST_BACKOFF_LEN      = 8'd5;

	localparam logic [7:0] CNT_MAX8 = 8'd255;

	typedef struct packed {
		logic run;
		logic uplink_up;
		logic clock_ok;
		logic bringup_ok;
		logic peer_alive;
		logic remote_failed;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  link_state;
		logic        vpn_status_bit;
		logic        cmd_bringup;
		logic        cmd_teardown;
		logic        event_up;
		logic        event_down;
		logic [15:0] failure_count;
		logic [15:0] connect_count;
	} result_t;

	typedef struct packed {
		logic       alt_mode;
		logic [7:0] handshake_budget;
		logic [7:0] alt_budget;
		logic [7:0] silence_limit;
		logic [7:0] backoff_floor;
		logic [7:0] backoff_cap;
	} cfg_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] phase_cnt;
		logic [7:0] backoff_len;
	} core_state_t;

endpackage

// File: sv/tls_ifs.sv
// valid/ready channel interfaces of the tunnel link supervisor
interface tls_in_if;
	logic                valid;
	logic                ready;
	tls_pkg::in_item_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tls_out_if;
	logic                valid;
	logic                ready;
	tls_pkg::result_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tls_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [tls_pkg::CFG_IDX_W-1:0]       index;
	logic [tls_pkg::CFG_DATA_W-1:0]      wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: sv/tls_step.sv
// next-state and result logic for one tick of the supervisor
module tls_step #(
	parameter int COUNT_WIDTH = 16
) (
	input  tls_pkg::core_state_t    cur,
	input  logic [COUNT_WIDTH-1:0]  fail_cnt,
	input  logic [COUNT_WIDTH-1:0]  conn_cnt,
	input  tls_pkg::cfg_t           cfg,
	input  tls_pkg::in_item_t       item,
	output tls_pkg::core_state_t    nxt,
	output logic [COUNT_WIDTH-1:0]  fail_nxt,
	output logic [COUNT_WIDTH-1:0]  conn_nxt,
	output tls_pkg::result_t        res
);

	logic        stop;
	logic        in_con;
	logic        in_conn;
	logic        in_bo;
	logic [7:0]  budget;
	logic        con_fail;
	logic        con_ok;
	logic        bo_wait;
	logic        wchk;
	logic        go;
	logic [7:0]  silent_nxt;
	logic        leave;
	logic [8:0]  twice;
	logic [7:0]  blen_grown;
	logic        fail_inc;
	logic [COUNT_WIDTH+15:0] fail_ext;
	logic [COUNT_WIDTH+15:0] conn_ext;
	tls_pkg::phase_t         phase_n;

	// decisions of this tick
	always_comb begin
		stop    = !item.run;
		in_con  = (cur.phase == tls_pkg::PH_CONNECTING);
		in_conn = (cur.phase == tls_pkg::PH_CONNECTED);
		in_bo   = (cur.phase == tls_pkg::PH_BACKOFF);
		budget  = cfg.alt_mode ? cfg.alt_budget : cfg.handshake_budget;
		go      = item.uplink_up && item.clock_ok;

		con_fail = item.run && in_con &&
			((cur.phase_cnt == 8'd0 && !item.bringup_ok) || cur.phase_cnt >= budget ||
			!item.uplink_up || (cfg.alt_mode && item.remote_failed));
		con_ok   = item.run && in_con && !con_fail && item.peer_alive;
		bo_wait  = item.run && in_bo && cur.phase_cnt > 8'd1;
		wchk     = item.run && !in_con && !in_conn && !bo_wait;

		silent_nxt = (cur.phase_cnt < tls_pkg::CNT_MAX8) ? cur.phase_cnt + 8'd1 : cur.phase_cnt;
		leave      = !item.uplink_up || (!item.peer_alive && silent_nxt >= cfg.silence_limit);

		twice      = {cur.backoff_len, 1'b0};
		blen_grown = (twice > {1'b0, cfg.backoff_cap}) ? cfg.backoff_cap : twice[7:0];
		fail_inc   = (stop && in_con) || con_fail;
	end

	// next phase
	always_comb begin
		phase_n = cur.phase;
		if (stop) begin
			phase_n = tls_pkg::PH_DISABLED;
		end else begin
			case (cur.phase)
				tls_pkg::PH_CONNECTING: begin
					if (con_fail) phase_n = tls_pkg::PH_BACKOFF;
					else if (con_ok) phase_n = tls_pkg::PH_CONNECTED;
				end
				tls_pkg::PH_CONNECTED: begin
					if (leave) phase_n = tls_pkg::PH_WAITING;
				end
				tls_pkg::PH_BACKOFF: begin
					if (!bo_wait) phase_n = go ? tls_pkg::PH_CONNECTING : tls_pkg::PH_WAITING;
				end
				default: begin
					phase_n = go ? tls_pkg::PH_CONNECTING : tls_pkg::PH_WAITING;
				end
			endcase
		end
	end

	// counters and result word
	always_comb begin
		nxt.phase       = phase_n;
		nxt.phase_cnt   = 8'd0;
		nxt.backoff_len = cur.backoff_len;
		if (stop) begin
			nxt.phase_cnt = 8'd0;
		end else if (con_fail) begin
			nxt.phase_cnt   = cur.backoff_len;
			nxt.backoff_len = blen_grown;
		end else if (con_ok) begin
			nxt.backoff_len = cfg.backoff_floor;
		end else if (in_con) begin
			nxt.phase_cnt = cur.phase_cnt + 8'd1;
		end else if (in_conn) begin
			nxt.phase_cnt = (leave || item.peer_alive) ? 8'd0 : silent_nxt;
		end else if (bo_wait) begin
			nxt.phase_cnt = cur.phase_cnt - 8'd1;
		end

		fail_nxt = (fail_inc && fail_cnt != '1) ? fail_cnt + 1'b1 : fail_cnt;
		conn_nxt = (con_ok && conn_cnt != '1) ? conn_cnt + 1'b1 : conn_cnt;
		fail_ext = {16'd0, fail_nxt};
		conn_ext = {16'd0, conn_nxt};

		res.link_state     = phase_n;
		res.vpn_status_bit = (phase_n == tls_pkg::PH_CONNECTED);
		res.cmd_bringup    = wchk && go;
		res.cmd_teardown   = (stop && (in_con || in_conn)) || con_fail ||
			(item.run && in_conn && leave);
		res.event_up       = con_ok;
		res.event_down     = in_conn && (stop || leave);
		res.failure_count  = fail_ext[15:0];
		res.connect_count  = conn_ext[15:0];
	end

endmodule

// File: sv/tunnel_link_supervisor_core.sv
// top level of the tunnel link supervisor: registers, handshakes and checks
//
// usage:
//  - item channel: one word per one-second tick with the sampled flags
//    (run, uplink_up, clock_ok, bringup_ok, peer_alive, remote_failed)
//  - result channel: one word per item with the phase after the tick,
//    status bit, bring-up/teardown commands, up/down events and the
//    saturating failure and connect counts (low 16 bits shown)
//  - cfg channel: register writes by index, always ready; write only while
//    no item is in flight. writing backoff_floor also reloads the backoff
//  - order: an accepted word is held in the input stage, then its result
//    is registered in the result register, from which the result channel
//    presents it
//  - throughput: one word per cycle while results are taken; the tick update
//    is a single pass of small compares and 8/COUNT_WIDTH-bit increments
//    between the input stage and the result register
//  - reset: supervisor disabled, counts zero, backoff length 5 and all
//    configuration registers at their defaults; both channels empty
//  - stall: a held result keeps the input stage full; the item channel
//    drops ready only once both the input stage and the result wait
module tunnel_link_supervisor_core #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	tls_in_if.sink          item,
	tls_out_if.source       result,
	tls_cfg_if.sink         cfg
);

	// configuration registers
	tls_pkg::cfg_t          cfg_q;

	// supervisor state
	tls_pkg::core_state_t   state_q;
	logic [COUNT_WIDTH-1:0] fail_q;
	logic [COUNT_WIDTH-1:0] conn_q;

	// input stage and result register
	logic                   valid_s1;
	tls_pkg::in_item_t      item_s1;
	logic                   res_valid_q;
	tls_pkg::result_t       res_q;

	tls_pkg::core_state_t   state_nxt;
	logic [COUNT_WIDTH-1:0] fail_nxt;
	logic [COUNT_WIDTH-1:0] conn_nxt;
	tls_pkg::result_t       res_nxt;

	logic                   adv_s1;
	logic                   in_fire;
	logic                   cfg_fire;

	// stage 1 moves on when the result slot is free or being emptied
	assign adv_s1     = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv_s1;
	assign in_fire    = item.valid && item.ready;
	assign cfg.ready  = 1'b1;
	assign cfg_fire   = cfg.valid;

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	tls_step #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_step (
		.cur      (state_q),
		.fail_cnt (fail_q),
		.conn_cnt (conn_q),
		.cfg      (cfg_q),
		.item     (item_s1),
		.nxt      (state_nxt),
		.fail_nxt (fail_nxt),
		.conn_nxt (conn_nxt),
		.res      (res_nxt)
	);

	// handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (in_fire) valid_s1 <= 1'b1;
			else if (adv_s1) valid_s1 <= 1'b0;
			if (adv_s1) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) item_s1 <= item.data;
		if (adv_s1) res_q <= res_nxt;
	end

	// supervisor state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alt_mode         <= 1'b0;
			cfg_q.handshake_budget <= tls_pkg::RST_HANDSHAKE_BUDGET;
			cfg_q.alt_budget       <= tls_pkg::RST_ALT_BUDGET;
			cfg_q.silence_limit    <= tls_pkg::RST_SILENCE_LIMIT;
			cfg_q.backoff_floor    <= tls_pkg::RST_BACKOFF_FLOOR;
			cfg_q.backoff_cap      <= tls_pkg::RST_BACKOFF_CAP;
			state_q.phase          <= tls_pkg::PH_DISABLED;
			state_q.phase_cnt      <= 8'd0;
			state_q.backoff_len    <= tls_pkg::RST_BACKOFF_LEN;
			fail_q                 <= '0;
			conn_q                 <= '0;
		end else begin
			if (adv_s1) begin
				state_q <= state_nxt;
				fail_q  <= fail_nxt;
				conn_q  <= conn_nxt;
			end
			// config writes must come only while idle; the block itself does not enforce this
			if (cfg_fire) begin
				case (cfg.index)
					tls_pkg::REG_ALT_MODE:         cfg_q.alt_mode <= cfg.wdata[0];
					tls_pkg::REG_HANDSHAKE_BUDGET: cfg_q.handshake_budget <= cfg.wdata;
					tls_pkg::REG_ALT_BUDGET:       cfg_q.alt_budget <= cfg.wdata;
					tls_pkg::REG_SILENCE_LIMIT:    cfg_q.silence_limit <= cfg.wdata;
					tls_pkg::REG_BACKOFF_FLOOR: begin
						cfg_q.backoff_floor <= cfg.wdata;
						state_q.backoff_len <= cfg.wdata;
					end
					tls_pkg::REG_BACKOFF_CAP:      cfg_q.backoff_cap <= cfg.wdata;
					default: begin
					end
				endcase
			end
		end
	end

	// the registered result always reports the phase just stored
	a_state_matches_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> res_q.link_state == state_q.phase)
		else $error("result phase differs from stored phase");

	// failure count never goes backwards
	a_fail_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> fail_q >= $past(fail_q))
		else $error("failure count decreased");

	// entering connected never tears down in the same tick
	a_up_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.event_up) |->
		(res_q.link_state == tls_pkg::PH_CONNECTED && !res_q.cmd_teardown))
		else $error("event_up with wrong phase or teardown");

endmodule
